@@ rtl/rau_pkg.sv @@
// package for the rational arithmetic unit: widths, operation, status, pass and state codes
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int DW = 2 * WORD_BITS;
  localparam int CW = $clog2(DW);

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CMP  = 3'd4,
    OP_NORM = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PASS_A = 2'd0,
    PASS_B = 2'd1,
    PASS_R = 2'd2
  } pass_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LOAD,
    S_SHIFT,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_POST,
    S_MUL,
    S_FORM,
    S_FIN
  } state_t;

endpackage

@@ rtl/rational_arith_unit_top.sv @@
// rational arithmetic unit: normalise two fractions, then add, subtract, multiply, divide or compare
// each reduction runs a binary gcd loop and then two restoring divisions by the gcd
// add, subtract, multiply and divide reduce three times; normalise reduces only the first fraction
// no new request is taken until the result is loaded; in_ready is high only while idle
// reset: synchronous, clears the sequencer and out_valid; no result is pending afterwards
module rational_arith_unit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] res_num,
  output logic [30:0] res_den,
  output logic        less_than,
  output logic        equal_to,
  output logic [1:0]  status
);
  import rau_pkg::*;

  localparam logic [DW-1:0] LIM  = DW'(1) << (WORD_BITS - 1);
  localparam logic [DW-1:0] MAXP = LIM - DW'(1);

  state_t state, state_next;

  op_t                        op;
  logic                       use_b;
  pass_t                      pass;
  logic signed [WORD_BITS-1:0] an, ad, bn, bd;
  logic signed [DW-1:0]       m0, m1, m2, pnr;
  logic [1:0]                 mul_step;
  logic [DW-1:0]              x, y, um, ud, g, qn, dq, dr;
  logic                       neg;
  logic [CW-1:0]              cnt;

  logic signed [WORD_BITS-1:0] f_num;
  logic [WORD_BITS-1:0]       f_den;
  logic                       f_lt, f_eq;
  status_t                    f_st;

  function automatic logic [DW-1:0] mag_dw(input logic signed [DW-1:0] v);
    mag_dw = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // load sources for the current reduction pass
  logic signed [DW-1:0] ld_n, ld_d;
  always_comb begin
    case (pass)
      PASS_A:  begin ld_n = DW'(an); ld_d = DW'(ad); end
      PASS_B:  begin ld_n = DW'(bn); ld_d = DW'(bd); end
      default: begin ld_n = pnr;     ld_d = m1;      end
    endcase
  end

  // shared multiplier
  logic signed [WORD_BITS-1:0] mul_a, mul_b;
  logic signed [DW-1:0]        prod;
  always_comb begin
    case (mul_step)
      2'd0:    begin mul_a = an; mul_b = (op == OP_MUL) ? bn : bd; end
      2'd1:    begin mul_a = ad; mul_b = (op == OP_DIV) ? bn : bd; end
      default: begin mul_a = bn; mul_b = ad; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // restoring divider step
  logic [DW+1:0] dsub;
  logic          dge;
  logic [DW-1:0] dr_step, dq_step;
  assign dsub    = {1'b0, dr, dq[DW-1]} - {2'b00, g};
  assign dge     = !dsub[DW+1];
  assign dr_step = dge ? dsub[DW-1:0] : {dr[DW-2:0], dq[DW-1]};
  assign dq_step = {dq[DW-2:0], dge};

  // fit check after a reduction
  logic signed [DW-1:0] sv;
  logic                 fit;
  assign sv  = neg ? DW'(-$signed(qn)) : $signed(qn);
  assign fit = (neg ? (qn <= LIM) : (qn <= MAXP)) && (dq <= MAXP);

  logic load_out;
  assign load_out = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (ad == '0 || (use_b && bd == '0)) state_next = S_FIN;
        else state_next = S_LOAD;
      end
      S_LOAD: begin
        if (pass == PASS_R && m1 == '0) state_next = S_FIN;
        else if (ld_n == '0) state_next = S_POST;
        else state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (x[0] || y[0]) state_next = S_GCD;
      end
      S_GCD: begin
        if (x == '0 || y == '0) state_next = S_DIVN;
      end
      S_DIVN: begin
        if (cnt == CW'(DW - 1)) state_next = S_DIVD;
      end
      S_DIVD: begin
        if (cnt == CW'(DW - 1)) state_next = S_POST;
      end
      S_POST: begin
        if (!fit) state_next = S_FIN;
        else if (pass == PASS_A && use_b) state_next = S_LOAD;
        else if (pass == PASS_B) state_next = S_MUL;
        else state_next = S_FIN;
      end
      S_MUL: begin
        if (mul_step == 2'd2) state_next = S_FORM;
      end
      S_FORM: begin
        if (op == OP_CMP) state_next = S_FIN;
        else state_next = S_LOAD;
      end
      S_FIN: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op    <= (req_type > 3'd5) ? OP_NORM : op_t'(req_type);
          use_b <= (req_type <= 3'd4);
          an    <= a_num[WORD_BITS-1:0];
          ad    <= a_den[WORD_BITS-1:0];
          bn    <= b_num[WORD_BITS-1:0];
          bd    <= b_den[WORD_BITS-1:0];
        end
      end
      S_CHECK: begin
        f_num <= '0;
        f_den <= '0;
        f_lt  <= 1'b0;
        f_eq  <= 1'b0;
        f_st  <= (ad == '0 || (use_b && bd == '0)) ? ST_ZERO : ST_OK;
        pass  <= PASS_A;
      end
      S_LOAD: begin
        if (pass == PASS_R && m1 == '0) f_st <= ST_ZERO;
        x   <= mag_dw(ld_n);
        y   <= mag_dw(ld_d);
        neg <= ld_n[DW-1] ^ ld_d[DW-1];
        // zero reduces straight to 0/1
        qn  <= '0;
        dq  <= DW'(1);
        g   <= DW'(1);
        dr  <= '0;
        cnt <= '0;
      end
      S_SHIFT: begin
        if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
        end else begin
          um <= x;
          ud <= y;
        end
      end
      S_GCD: begin
        if (x == '0 || y == '0) begin
          g   <= x | y;
          dq  <= um;
          dr  <= '0;
          cnt <= '0;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x >= y) begin
          x <= x - y;
        end else begin
          y <= y - x;
        end
      end
      S_DIVN: begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DW - 1)) begin
          qn <= dq_step;
          dq <= ud;
          dr <= '0;
        end else begin
          dq <= dq_step;
          dr <= dr_step;
        end
      end
      S_DIVD: begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DW - 1)) begin
          dq <= dq_step;
        end else begin
          dq <= dq_step;
          dr <= dr_step;
        end
      end
      S_POST: begin
        if (!fit) begin
          f_st <= ST_OVF;
        end else begin
          case (pass)
            PASS_A: begin
              an <= sv[WORD_BITS-1:0];
              ad <= dq[WORD_BITS-1:0];
              if (use_b) pass <= PASS_B;
              else begin
                f_num <= sv[WORD_BITS-1:0];
                f_den <= dq[WORD_BITS-1:0];
              end
            end
            PASS_B: begin
              bn       <= sv[WORD_BITS-1:0];
              bd       <= dq[WORD_BITS-1:0];
              mul_step <= 2'd0;
            end
            default: begin
              f_num <= sv[WORD_BITS-1:0];
              f_den <= dq[WORD_BITS-1:0];
            end
          endcase
        end
      end
      S_MUL: begin
        mul_step <= mul_step + 2'd1;
        case (mul_step)
          2'd0:    m0 <= prod;
          2'd1:    m1 <= prod;
          default: m2 <= prod;
        endcase
      end
      S_FORM: begin
        pass <= PASS_R;
        case (op)
          OP_ADD:  pnr <= m0 + m2;
          OP_SUB:  pnr <= m0 - m2;
          OP_CMP: begin
            f_lt <= (m0 < m2);
            f_eq <= (an == bn) && (ad == bd);
          end
          default: pnr <= m0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_num   <= 32'(f_num);
      res_den   <= 31'(f_den);
      less_than <= f_lt;
      equal_to  <= f_eq;
      status    <= f_st;
    end
  end

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |->
      (res_num == '0 && res_den == '0 && !less_than && !equal_to))
    else $error("error result carries data");

  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (less_than || equal_to)) |->
      (status == ST_OK && res_num == '0 && res_den == '0))
    else $error("compare flags with fraction data");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

endmodule

@@ tb/sv/tb_rational_arith_unit_top.sv @@
// testbench for the rational arithmetic unit: random and directed requests checked against a predictor
`timescale 1ns / 100ps

module tb_rational_arith_unit_top;
  import rau_pkg::*;

  localparam int LIMIT_CYCLES = 8000000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int QUIET_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 1200;
  localparam logic [31:0] W_MIN = 32'h8000_0000;
  localparam logic [31:0] W_MAX = 32'h7fff_ffff;
  localparam logic [31:0] W_M1  = 32'hffff_ffff;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        lt;
    logic        eq;
    status_t     st;
  } rau_result_t;

  class rau_scoreboard;
    rau_result_t expected_q[$];
    int errors = 0;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void reduce(longint n, longint d, output longint rn, output longint rd);
      longint unsigned mn, md, x, y, g;
      mn = (n < 0) ? -n : n;
      md = (d < 0) ? -d : d;
      x = mn;
      y = md;
      while (x != 0 && y != 0) begin
        if (x > y) x = x % y;
        else y = y % x;
      end
      g = x + y;
      if (g == 0) g = 1;
      mn = mn / g;
      md = md / g;
      if (mn == 0) begin
        rn = 0;
        rd = 1;
      end else begin
        rn = ((n < 0) != (d < 0)) ? -longint'(mn) : longint'(mn);
        rd = longint'(md);
      end
    endfunction

    function bit fits(longint n, longint d);
      longint hi;
      hi = 64'sd2147483647;
      return n >= -hi - 1 && n <= hi && d >= 1 && d <= hi;
    endfunction

    function rau_result_t predict(logic [2:0] code, logic [31:0] an_r, logic [31:0] ad_r,
                                  logic [31:0] bn_r, logic [31:0] bd_r);
      rau_result_t r;
      op_t op;
      longint an, ad, bn, bd, pn, pd, rn, rd;
      bit use_b;
      an = longint'($signed(an_r));
      ad = longint'($signed(ad_r));
      bn = longint'($signed(bn_r));
      bd = longint'($signed(bd_r));
      use_b = code <= OP_CMP;
      op = (code > OP_NORM) ? OP_NORM : op_t'(code);
      r = '0;
      r.st = ST_OK;
      rn = 0;
      rd = 0;
      if (ad == 0 || (use_b && bd == 0)) begin
        r.st = ST_ZERO;
      end else begin
        reduce(an, ad, an, ad);
        if (use_b) reduce(bn, bd, bn, bd);
        if (!fits(an, ad) || (use_b && !fits(bn, bd))) begin
          r.st = ST_OVF;
        end else begin
          case (op)
            OP_ADD: begin pn = an * bd + bn * ad; pd = ad * bd; end
            OP_SUB: begin pn = an * bd - bn * ad; pd = ad * bd; end
            OP_MUL: begin pn = an * bn; pd = ad * bd; end
            OP_DIV: begin pn = an * bd; pd = ad * bn; end
            OP_CMP: begin pn = 0; pd = 0; end
            default: begin pn = an; pd = ad; end
          endcase
          if (op == OP_CMP) begin
            r.lt = (an * bd < bn * ad);
            r.eq = (an == bn && ad == bd);
          end else if (pd == 0) begin
            r.st = ST_ZERO;
          end else begin
            reduce(pn, pd, rn, rd);
            if (!fits(rn, rd)) begin
              r.st = ST_OVF;
              rn = 0;
              rd = 0;
            end
          end
        end
      end
      r.num = rn[31:0];
      r.den = rd[30:0];
      return r;
    endfunction

    function void note(logic [2:0] code, logic [31:0] an, logic [31:0] ad,
                       logic [31:0] bn, logic [31:0] bd);
      expected_q.insert(expected_q.size(), predict(code, an, ad, bn, bd));
    endfunction

    task check(rau_result_t got);
      rau_result_t want;
      if (expected_q.size() == 0) begin
        report("result with no request pending");
      end else begin
        want = expected_q.pop_front();
        if (got.num !== want.num) report($sformatf("res_num %h want %h", got.num, want.num));
        if (got.den !== want.den) report($sformatf("res_den %h want %h", got.den, want.den));
        if (got.lt !== want.lt) report($sformatf("less_than %b want %b", got.lt, want.lt));
        if (got.eq !== want.eq) report($sformatf("equal_to %b want %b", got.eq, want.eq));
        if (got.st !== want.st) report($sformatf("status %0d want %0d", got.st, want.st));
      end
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  req_type = '0;
  logic [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic        less_than, equal_to;
  logic [1:0]  status;

  rau_scoreboard sb = new();
  bit quiet = 0;
  int cycles = 0;
  int ready_hold = 0;

  rational_arith_unit_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_num(res_num), .res_den(res_den), .less_than(less_than), .equal_to(equal_to),
    .status(status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_rational_arith_unit_top failed");
      $finish;
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 0;
    end else if (quiet) begin
      out_ready = 1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ready = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      ready_hold = $urandom_range(1, 14) - 1;
      out_ready = 0;
    end else begin
      out_ready = 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check({res_num, res_den, less_than, equal_to, status_t'(status)});
  end

  task send_request(logic [2:0] code, logic [31:0] an, logic [31:0] ad,
                    logic [31:0] bn, logic [31:0] bd);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid = 1;
    req_type = code;
    a_num = an;
    a_den = ad;
    b_num = bn;
    b_den = bd;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note(code, an, ad, bn, bd);
    @(negedge clk);
  endtask

  function logic [31:0] rand_word(bit den);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 4))
          0: return W_MIN;
          1: return W_MAX;
          2: return W_M1;
          3: return 32'd1;
          default: return den ? 32'd2 : 32'd0;
        endcase
      end
      2, 3: return 32'($signed($urandom_range(0, 131070)) - 65535);
      default: return 32'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  function logic [31:0] rand_den();
    logic [31:0] v;
    v = rand_word(1);
    if (v == 0 && $urandom_range(0, 3) != 0) v = 32'd1;
    return v;
  endfunction

  task run_random(int count);
    logic [2:0] code;
    for (int i = 0; i < count; i++) begin
      if (i == count - QUIET_ITEMS) quiet = 1;
      if (i == count / 2) begin
        in_valid = 0;
        while (sb.expected_q.size() != 0) @(negedge clk);
      end
      code = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_request(code, rand_word(0), rand_den(), rand_word(0), rand_den());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send_request(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_request(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_request(OP_MUL, 32'd6, W_M1, 32'd4, 32'd9);
    send_request(OP_DIV, 32'd3, 32'd4, W_M1, 32'd8);
    send_request(OP_CMP, 32'd2, 32'd4, 32'd1, 32'd2);
    send_request(OP_CMP, W_M1, 32'd3, 32'd1, 32'd3);
    send_request(OP_NORM, 32'd12, 32'hffff_fff8, 32'd5, 32'd0);
    send_request(3'd6, 32'd0, W_MIN, 32'd1, 32'd1);
    send_request(3'd7, W_MAX, W_MAX, 32'd0, 32'd0);
    send_request(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_request(OP_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
    send_request(OP_NORM, W_MIN, W_M1, 32'd1, 32'd1);
    send_request(OP_MUL, 32'd1, 32'd1, W_MIN, W_MIN);
    send_request(OP_DIV, 32'd5, 32'd7, 32'd0, 32'd3);
    send_request(OP_ADD, W_MAX, 32'd1, W_MAX, 32'd1);
    send_request(OP_SUB, W_MIN, 32'd1, 32'd1, 32'd1);
    send_request(OP_MUL, W_MAX, 32'd1, W_MAX, 32'd1);
    send_request(OP_DIV, 32'd1, W_MAX, W_MAX, 32'd1);
    send_request(OP_ADD, 32'd1, W_MAX, 32'd1, 32'h7fff_fffe);
    send_request(OP_CMP, W_MIN, 32'd1, W_MAX, 32'd1);
    send_request(OP_CMP, W_MIN, W_MIN, W_M1, W_M1);
    send_request(OP_MUL, 32'd0, 32'd5, W_MAX, 32'd3);
    run_random(RANDOM_ITEMS);
    in_valid = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_rational_arith_unit_top passed");
    end else begin
      $display("tb_rational_arith_unit_top failed");
    end
    $finish;
  end

endmodule
